// ===== sv/line_substring_match_filter_defines.svh =====
// Assertion macros shared by the line substring match filter modules.
`ifndef LINE_SUBSTRING_MATCH_FILTER_DEFINES_SVH
`define LINE_SUBSTRING_MATCH_FILTER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define LSMF_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define LSMF_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== sv/lsmf_pkg.sv =====
// Types and constants of the line substring match filter.
package lsmf_pkg;

   localparam int KEY_BYTES = 32;
   localparam int KEY_IDX_W = $clog2(KEY_BYTES);
   localparam int LEN_W     = 16;

   localparam logic [2:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD0  = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD3  = 3'd4;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CHAR_NUL = 8'd0;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic             matched;
      logic [LEN_W-1:0] line_length;
   } rsp_type;

   // Key as seen by every window cell.
   typedef struct packed {
      logic [5:0]                key_length;
      logic [KEY_BYTES-1:0][7:0] key_bytes;
   } key_type;

endpackage

// ===== sv/line_substring_match_filter.sv =====
// Line substring match filter top level: config registers, window cell chain, line state.
`include "line_substring_match_filter_defines.svh"

// Takes one byte per cycle unless the result buffer is full, and reports, for each
// nonempty line ended by NUL, CR, LF or an end-of-stream item, whether the
// configured key occurs in it and the line length. Each byte shifts a chain of KEY_MAX
// cells; all cells compare against the key in the same cycle, and the result of a line
// is registered in the result buffer once its terminator is transferred. A two-entry
// result buffer lets input keep flowing while one result waits; input stalls only when
// both entries are full. Key registers may be rewritten between any two items and apply from the next byte.
module line_substring_match_filter #(
   parameter int KEY_MAX = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsmf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);

   localparam int WORDS = lsmf_pkg::KEY_BYTES / 8;

   logic [5:0]             key_length_ff;
   logic [WORDS-1:0][63:0] key_words_ff;
   logic [1:0]             word_sel;
   lsmf_pkg::key_type      key;

   logic [lsmf_pkg::LEN_W-1:0] count_ff, count_in, count_next;
   logic                       seen_ff, seen_in;

   logic                  take, line_end, shift, clear, hit;
   logic [KEY_MAX:0][7:0] chain;
   logic [KEY_MAX-1:0]    equal;

   logic              res_valid, res_ready;
   lsmf_pkg::rsp_type res_data;

   // Configuration
   assign csr_ready = 1'b1;
   assign word_sel  = 2'(csr_index - lsmf_pkg::CSR_KEY_WORD0);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 6'd0;
         key_words_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == lsmf_pkg::CSR_KEY_LENGTH) begin
            key_length_ff <= csr_data[5:0];
         end else if (csr_index <= lsmf_pkg::CSR_KEY_WORD3) begin
            key_words_ff[word_sel] <= csr_data;
         end
      end
   end

   assign key.key_length = key_length_ff;
   assign key.key_bytes  = key_words_ff;

   // Input side
   assign req_ready = res_ready;
   assign take      = req_valid && req_ready;
   assign line_end  = (req_data.kind == lsmf_pkg::KIND_END)
                   || (req_data.byte_value == lsmf_pkg::CHAR_NUL)
                   || (req_data.byte_value == lsmf_pkg::CHAR_CR)
                   || (req_data.byte_value == lsmf_pkg::CHAR_LF);
   assign shift     = take && !line_end;
   assign clear     = take && line_end;

   assign chain[0] = req_data.byte_value;

   for (genvar i = 0; i < KEY_MAX; i++) begin : g_cell
      lsmf_cell #(.INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .clear    (clear),
         .key      (key),
         .byte_in  (chain[i]),
         .byte_out (chain[i+1]),
         .equal    (equal[i])
      );
   end

   assign count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   // Window after this byte must hold the key and the line must be long enough.
   assign hit = (key_length_ff != 6'd0)
             && ({1'b0, key_length_ff} <= 7'(KEY_MAX))
             && (&equal)
             && (count_next >= lsmf_pkg::LEN_W'(key_length_ff));

   always_comb begin
      count_in = count_ff;
      seen_in  = seen_ff;
      if (clear) begin
         count_in = '0;
         seen_in  = 1'b0;
      end else if (shift) begin
         count_in = count_next;
         seen_in  = seen_ff || hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   assign res_valid            = clear && (count_ff != '0);
   assign res_data.matched     = seen_ff || (key_length_ff == 6'd0);
   assign res_data.line_length = count_ff;

   lsmf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (res_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   `LSMF_ASSERT_NEXT(a_end_clears_line, clock, reset, clear, count_ff == '0 && !seen_ff, "line state kept past line end")
   `LSMF_ASSERT_NOW(a_result_nonempty, clock, reset, rsp_valid, rsp_data.line_length != '0, "result for empty line")

endmodule

// ===== sv/lsmf_cell.sv =====
// One window cell: holds a line byte and compares its incoming byte to its key byte.
module lsmf_cell #(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             clear,
   input  lsmf_pkg::key_type key,
   input  logic [7:0]       byte_in,
   output logic [7:0]       byte_out,
   output logic             equal
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;
   logic [6:0] key_pos;
   logic       active;
   logic [7:0] key_byte;

   // After the shift this cell holds window byte INDEX, which lines up with
   // key byte key_length-1-INDEX.
   assign active  = 7'(INDEX) < {1'b0, key.key_length};
   assign key_pos = {1'b0, key.key_length} - 7'(INDEX) - 7'd1;

   always_comb begin
      if (key_pos < 7'(lsmf_pkg::KEY_BYTES)) begin
         key_byte = key.key_bytes[key_pos[lsmf_pkg::KEY_IDX_W-1:0]];
      end else begin
         key_byte = 8'd0;
      end
   end

   assign equal = !active || (byte_in == key_byte);

   always_comb begin
      if (clear) begin
         byte_in_next = 8'd0;
      end else if (shift) begin
         byte_in_next = byte_in;
      end else begin
         byte_in_next = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ===== sv/lsmf_rsp_buf.sv =====
// Result buffer: output register plus skid register between the two sides.
`include "line_substring_match_filter_defines.svh"

module lsmf_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lsmf_pkg::rsp_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output lsmf_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lsmf_pkg::rsp_type out_ff, out_in;
   lsmf_pkg::rsp_type skid_ff, skid_in;
   logic              load;

   assign in_ready = !skid_valid_ff;
   assign load     = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !out_ready) begin
         if (load) begin
            skid_valid_in = 1'b1;
            skid_in       = in_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = load;
         out_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   `LSMF_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid full while output empty")
   `LSMF_ASSERT_NEXT(a_stall_fills_skid, clock, reset, out_valid_ff && !out_ready && load, skid_valid_ff, "stalled transfer lost")

endmodule

// ===== verif/line_substring_match_filter_test.sv =====
// Testbench for the line substring match filter: random lines and keys, self-checking.
`timescale 1ns / 100ps

module line_substring_match_filter_test;

   localparam int          WINDOW        = lsmf_pkg::KEY_BYTES;
   localparam int          LEN_SAT       = 65535;
   localparam int          DRAIN_CYCLES  = 16;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam logic [2:0]  CSR_KEY_WORD1 = lsmf_pkg::CSR_KEY_WORD0 + 3'd1;
   localparam logic [2:0]  CSR_KEY_WORD2 = lsmf_pkg::CSR_KEY_WORD0 + 3'd2;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lsmf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lsmf_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [63:0]       csr_data  = '0;

   line_substring_match_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the line state and key registers.
   logic [7:0]  line_window [WINDOW];
   int unsigned line_count = 0;
   bit          line_hit   = 1'b0;
   logic [5:0]  key_len    = '0;
   logic [63:0] key_word [4];

   lsmf_pkg::req_type text_q [$];
   lsmf_pkg::rsp_type line_reports_q [$];
   bit          req_busy     = 1'b0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          calm_left    = 0;
   int          fault_count  = 0;
   int          cycle_count  = 0;

   initial begin
      foreach (line_window[i]) line_window[i] = '0;
      foreach (key_word[i]) key_word[i] = '0;
   end

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] key_byte_at(int i);
      if (i >= WINDOW) return 8'd0;
      return key_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic bit window_has_key();
      int n;
      n = key_len;
      if (n == 0 || n > WINDOW || line_count < n) return 1'b0;
      for (int j = 0; j < n; j++) begin
         if (line_window[n - 1 - j] != key_byte_at(j)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void close_line();
      lsmf_pkg::rsp_type r;
      if (line_count > 0) begin
         r.matched     = line_hit || (key_len == 0);
         r.line_length = line_count[lsmf_pkg::LEN_W-1:0];
         line_reports_q.push_back(r);
      end
      foreach (line_window[i]) line_window[i] = '0;
      line_count = 0;
      line_hit   = 1'b0;
   endfunction

   function automatic void scan_text_byte(lsmf_pkg::req_type t);
      if (t.kind == lsmf_pkg::KIND_END ||
          t.byte_value inside {lsmf_pkg::CHAR_NUL, lsmf_pkg::CHAR_CR, lsmf_pkg::CHAR_LF}) begin
         close_line();
      end else begin
         for (int i = WINDOW - 1; i > 0; i--) line_window[i] = line_window[i - 1];
         line_window[0] = t.byte_value;
         if (line_count < LEN_SAT) line_count++;
         if (window_has_key()) line_hit = 1'b1;
      end
   endfunction

   function automatic void log_fault(string msg);
      if (fault_count < 10) $display("%s", msg);
      fault_count++;
   endfunction

   // Transfer detection on the input channel; prediction runs on each accepted byte.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         scan_text_byte(req_data);
         req_busy = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 60);
      rsp_ready <= (calm_left > 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
      if (!req_busy) begin
         if (!reset && text_q.size() > 0 &&
             (calm_left > 0 || $urandom_range(0, 99) >= snd_idle_pct)) begin
            req_data  <= text_q.pop_front();
            req_valid <= 1'b1;
            req_busy   = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      lsmf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_reports_q.size() == 0) begin
            log_fault($sformatf("unexpected line result matched=%0d length=%0d",
                                rsp_data.matched, rsp_data.line_length));
         end else begin
            want = line_reports_q.pop_front();
            if (rsp_data.matched !== want.matched ||
                rsp_data.line_length !== want.line_length) begin
               log_fault($sformatf({"line result mismatch: expected matched=%0d length=%0d,",
                                    " got matched=%0d length=%0d"},
                                   want.matched, want.line_length,
                                   rsp_data.matched, rsp_data.line_length));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == lsmf_pkg::CSR_KEY_LENGTH) key_len = value[5:0];
      else if (idx >= lsmf_pkg::CSR_KEY_WORD0 && idx <= lsmf_pkg::CSR_KEY_WORD3)
         key_word[idx - lsmf_pkg::CSR_KEY_WORD0] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (text_q.size() != 0 || req_busy || line_reports_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void put_byte(logic [7:0] b);
      text_q.push_back(lsmf_pkg::req_type'{kind: lsmf_pkg::KIND_BYTE, byte_value: b});
   endfunction

   function automatic void put_end();
      text_q.push_back(lsmf_pkg::req_type'{kind: lsmf_pkg::KIND_END,
                                           byte_value: 8'($urandom_range(0, 255))});
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic logic [7:0] filler_byte();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h61, 8'h64));
   endfunction

   // One key setting followed by random lines, mostly well formed.
   task automatic run_key_phase(int budget);
      logic [7:0]  kb [WINDOW];
      logic [63:0] words [4];
      int          kl;
      int          pick;
      int          pattern;
      int          len;
      int          pos;
      int          used;
      bit          embed;
      logic [7:0]  b;
      pick = $urandom_range(0, 19);
      case (pick)
         0:       kl = 0;
         1:       kl = WINDOW;
         2:       kl = $urandom_range(WINDOW + 1, 63);
         3:       kl = 1;
         default: kl = $urandom_range(1, 12);
      endcase
      pattern = $urandom_range(0, 9);
      for (int i = 0; i < WINDOW; i++) begin
         if (pattern == 0) b = 8'hFF;
         else if (pattern == 1) b = 8'h00;
         else if (i >= kl) b = 8'($urandom_range(0, 255));
         else if ($urandom_range(0, 99) < 3) b = lsmf_pkg::CHAR_NUL;
         else if ($urandom_range(0, 99) < 80) b = 8'($urandom_range(8'h61, 8'h64));
         else begin
            b = 8'($urandom_range(1, 255));
            if (b == lsmf_pkg::CHAR_CR || b == lsmf_pkg::CHAR_LF) b = 8'h65;
         end
         kb[i] = b;
         words[i / 8][(i % 8) * 8 +: 8] = b;
      end
      csr_write(lsmf_pkg::CSR_KEY_WORD0, words[0]);
      csr_write(CSR_KEY_WORD1, words[1]);
      csr_write(CSR_KEY_WORD2, words[2]);
      csr_write(lsmf_pkg::CSR_KEY_WORD3, words[3]);
      csr_write(lsmf_pkg::CSR_KEY_LENGTH, 6'(kl));
      used = 0;
      while (used < budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) len = 0;
         else if (pick == 2) len = $urandom_range(WINDOW + 1, 70);
         else len = $urandom_range(1, 24);
         embed = (kl >= 1 && kl <= WINDOW && len >= kl && $urandom_range(0, 1) == 1);
         pos   = embed ? $urandom_range(0, len - kl) : 0;
         for (int i = 0; i < len; i++) begin
            if (embed && i >= pos && i < pos + kl) put_byte(kb[i - pos]);
            else if (pattern == 0 && $urandom_range(0, 1) == 1) put_byte(8'hFF);
            else put_byte(filler_byte());
         end
         used += len + 1;
         case ($urandom_range(0, 4))
            0: put_byte(lsmf_pkg::CHAR_NUL);
            1: put_byte(lsmf_pkg::CHAR_CR);
            2: put_byte(lsmf_pkg::CHAR_LF);
            3: put_end();
            default: begin
               put_byte(lsmf_pkg::CHAR_CR);
               put_byte(lsmf_pkg::CHAR_LF);
               used++;
            end
         endcase
      end
      // Sometimes leave a line open so the next key applies to its tail.
      if ($urandom_range(0, 9) < 3) begin
         repeat ($urandom_range(1, 6)) put_byte(filler_byte());
      end
      wait_quiet();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      snd_idle_pct = 31;
      rcv_idle_pct = 68;

      // Reset key is empty: every nonempty line matches, empty lines are silent.
      put_end();
      put_byte(lsmf_pkg::CHAR_CR);
      put_byte(8'hFF);
      put_byte(8'h01);
      put_byte(lsmf_pkg::CHAR_NUL);
      put_text("q");
      wait_quiet();

      // Key "ab" set while "q" is still pending.
      csr_write(lsmf_pkg::CSR_KEY_WORD0, 64'h6261);
      csr_write(CSR_KEY_WORD1, '1);
      csr_write(CSR_KEY_WORD2, '1);
      csr_write(lsmf_pkg::CSR_KEY_WORD3, '1);
      csr_write(lsmf_pkg::CSR_KEY_LENGTH, 6'd2);
      put_text("ab");
      put_byte(lsmf_pkg::CHAR_LF);
      // Split across a line end: no match.
      put_text("a");
      put_byte(lsmf_pkg::CHAR_LF);
      put_text("b");
      put_byte(lsmf_pkg::CHAR_LF);
      put_text("bab");
      put_end();
      wait_quiet();

      // Key longer than the window never matches.
      csr_write(lsmf_pkg::CSR_KEY_LENGTH, 6'd33);
      put_text("ab");
      put_byte(lsmf_pkg::CHAR_CR);
      wait_quiet();

      // Key holding a zero byte.
      csr_write(lsmf_pkg::CSR_KEY_WORD0, 64'h0061);
      csr_write(lsmf_pkg::CSR_KEY_LENGTH, 6'd2);
      put_text("a");
      put_byte(lsmf_pkg::CHAR_NUL);
      put_text("c");
      wait_quiet();

      // Empty key applied at line end.
      csr_write(lsmf_pkg::CSR_KEY_LENGTH, 6'd0);
      put_end();
      wait_quiet();

      for (int mode = 0; mode < 3; mode++) begin
         snd_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 68 : 0;
         rcv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 31 : 0;
         repeat (4) run_key_phase(100);
      end

      if (line_reports_q.size() != 0)
         log_fault($sformatf("%0d line results never arrived", line_reports_q.size()));
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
